// File: design/psh_pkg.sv
package psh_pkg;

	localparam int unsigned TableEntries = 1024;
	localparam int unsigned KeyW         = 32;
	localparam int unsigned PosW         = 10;
	localparam int unsigned CountW       = 11;
	localparam int unsigned EpochW       = 8;
	localparam logic [31:0] HashMul      = 32'h9E37_79B1;

	typedef struct packed {
		logic [EpochW-1:0] epoch;
		logic [KeyW-1:0]   key;
		logic [PosW-1:0]   pos;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

// File: design/psh_table.sv
module psh_table #(
	parameter int unsigned TABLE_ENTRIES = psh_pkg::TableEntries
) (
	input  logic                             clk,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
	input  logic                             rd_en,
	input  logic                             wr_en,
	input  psh_pkg::entry_t                  wr_data,
	output psh_pkg::entry_t                  rd_data
);

	psh_pkg::entry_t mem [TABLE_ENTRIES];
	psh_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/pair_sum_hash_lookup.sv
// Pair-sum lookup over a hash table held in one synchronous RAM with linear probing.
// Each s_ item is one array element; tuser marks the first element of an array, which
// starts an empty table and index 0. For each element the block looks up target_sum
// minus the value, then stores the value with its index (a repeated value updates the
// stored index), and returns one m_ item. It hashes the complement, then reads and
// compares one RAM slot per probe until it hits the key or a free slot or has tried all
// slots, then does the same for the value and stores it; each lookup probes at least once.
// When the complement is out of 32-bit range, its lookup and its hash step are skipped.
// The probes share the single RAM port, and a new item is taken only in the idle step. A
// result that waits on m_tready holds the block in its last step. Arrays are cleared by an
// epoch mark kept in each entry; after reset, and on every 255th new array, a clearing
// pass over all TABLE_ENTRIES addresses sweeps the RAM before the item goes on. cfg_we
// writes target_sum.
module pair_sum_hash_lookup #(
	parameter int unsigned TABLE_ENTRIES = psh_pkg::TableEntries
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tuser,  // first_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // pair_found, earlier_index[10:1], current_index[20:11],
	                              // table_full[21], zero fill
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned OW = AW + 1;
	localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);
	localparam logic [OW-1:0] Entries  = OW'(TABLE_ENTRIES);

	psh_pkg::state_t state_q;

	logic [31:0]                   target_q;
	logic [psh_pkg::KeyW-1:0]      value_q;
	logic [psh_pkg::KeyW-1:0]      comp_q;
	logic                          busy_q;
	logic                          phase_q;
	logic [AW-1:0]                 addr_q;
	logic [AW-1:0]                 probes_q;
	logic [OW-1:0]                 occ_q;
	logic [psh_pkg::EpochW-1:0]    epoch_q;
	logic [psh_pkg::CountW-1:0]    count_q;
	logic                          found_q;
	logic [psh_pkg::PosW-1:0]      earlier_q;
	logic                          full_q;
	logic                          out_valid_q;
	logic [23:0]                   out_data_q;

	logic [32:0]                   comp33;
	logic                          comp_ok;
	logic [psh_pkg::KeyW-1:0]      key_cur;
	logic [31:0]                   prod;
	logic [AW:0]                   hash_raw;
	logic [AW-1:0]                 hash_addr;
	logic [psh_pkg::EpochW-1:0]    epoch_next;
	logic                          out_free;
	logic                          live;
	logic                          match;
	logic [psh_pkg::PosW-1:0]      cur_pos;
	logic                          rd_en;
	logic                          wr_en;
	psh_pkg::entry_t               wr_data;
	psh_pkg::entry_t               rd_data;

	psh_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.addr   (addr_q),
		.rd_en  (rd_en),
		.wr_en  (wr_en),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	assign comp33   = {target_q[31], target_q} - {s_tdata[31], s_tdata};
	assign comp_ok  = (comp33[32] == comp33[31]);
	assign key_cur  = phase_q ? value_q : comp_q;
	assign prod     = key_cur * psh_pkg::HashMul;
	assign hash_raw = {1'b0, prod[31 -: AW]};
	// fold the top slice back into range for table sizes that are not a power of two
	assign hash_addr = (hash_raw >= Entries) ? AW'(hash_raw - Entries) : hash_raw[AW-1:0];
	assign epoch_next = epoch_q + psh_pkg::EpochW'(1);
	assign out_free  = !out_valid_q || m_tready;
	assign live      = (rd_data.epoch == epoch_q);
	assign match     = live && (rd_data.key == key_cur);
	assign cur_pos   = count_q[psh_pkg::PosW-1:0];
	assign rd_en     = (state_q == psh_pkg::ST_READ);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		if (state_q == psh_pkg::ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == psh_pkg::ST_CMP && phase_q) begin
			wr_data.epoch = epoch_q;
			wr_data.key   = value_q;
			wr_data.pos   = cur_pos;
			if (match) begin
				wr_en = 1'b1;
			end else if (!live && occ_q < Entries) begin
				wr_en = 1'b1;
			end
		end
	end

	assign s_tready = (state_q == psh_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_q <= s_tdata;
			comp_q  <= comp33[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psh_pkg::ST_CLEAR;
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			addr_q      <= '0;
			probes_q    <= '0;
			occ_q       <= '0;
			epoch_q     <= psh_pkg::EpochW'(1);
			count_q     <= '0;
			found_q     <= 1'b0;
			earlier_q   <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// the last step sets the output itself
			if (m_tvalid && m_tready && state_q != psh_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				psh_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						busy_q    <= 1'b1;
						phase_q   <= !comp_ok;
						found_q   <= 1'b0;
						earlier_q <= '0;
						full_q    <= 1'b0;
						addr_q    <= '0;
						if (s_tuser) begin
							occ_q   <= '0;
							count_q <= '0;
							// epoch wrap: restart at 1 and sweep stale marks out
							if (epoch_next == '0) begin
								epoch_q <= psh_pkg::EpochW'(1);
								state_q <= psh_pkg::ST_CLEAR;
							end else begin
								epoch_q <= epoch_next;
								state_q <= psh_pkg::ST_HASH;
							end
						end else begin
							state_q <= psh_pkg::ST_HASH;
						end
					end
				end
				psh_pkg::ST_CLEAR: begin
					if (addr_q == LastAddr) begin
						addr_q  <= '0;
						state_q <= busy_q ? psh_pkg::ST_HASH : psh_pkg::ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				psh_pkg::ST_HASH: begin
					addr_q   <= hash_addr;
					probes_q <= '0;
					state_q  <= psh_pkg::ST_READ;
				end
				psh_pkg::ST_READ: begin
					state_q <= psh_pkg::ST_CMP;
				end
				psh_pkg::ST_CMP: begin
					if (!phase_q) begin
						if (match || !live || probes_q == LastAddr) begin
							found_q   <= match;
							earlier_q <= match ? rd_data.pos : '0;
							phase_q   <= 1'b1;
							state_q   <= psh_pkg::ST_HASH;
						end else begin
							addr_q   <= (addr_q == LastAddr) ? '0 : addr_q + AW'(1);
							probes_q <= probes_q + AW'(1);
							state_q  <= psh_pkg::ST_READ;
						end
					end else begin
						if (match) begin
							state_q <= psh_pkg::ST_DONE;
						end else if (!live) begin
							if (occ_q < Entries) begin
								occ_q <= occ_q + OW'(1);
							end else begin
								full_q <= 1'b1;
							end
							state_q <= psh_pkg::ST_DONE;
						end else if (probes_q == LastAddr) begin
							full_q  <= 1'b1;
							state_q <= psh_pkg::ST_DONE;
						end else begin
							addr_q   <= (addr_q == LastAddr) ? '0 : addr_q + AW'(1);
							probes_q <= probes_q + AW'(1);
							state_q  <= psh_pkg::ST_READ;
						end
					end
				end
				psh_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, full_q, cur_pos, earlier_q, found_q};
						count_q     <= count_q + psh_pkg::CountW'(1);
						busy_q      <= 1'b0;
						state_q     <= psh_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= psh_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct packed {
		logic       full;
		logic [9:0] cur;
		logic [9:0] earlier;
		logic       found;
	} pair_result_t;

	typedef struct {
		logic [31:0]  value;
		bit           first;
		bit           typed;
		pair_result_t res;
	} element_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	pair_result_t expected_pairs[$];
	int           errors = 0;
	int           quiet_cycles = 0;
	bit           steady_flow = 1'b0;
	int           hold_off = 0;

	// predictor state
	int unsigned       stored_pos[int];
	int unsigned       slots_used = 0;
	logic [10:0]       elem_count = '0;
	logic signed [31:0] target = '0;

	pair_sum_hash_lookup i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d", field, got, want);
		errors++;
	endtask

	task automatic lookup_and_store(input logic [31:0] raw, input bit first,
			output pair_result_t r);
		longint comp;
		int     key;
		key = $signed(raw);
		if (first) begin
			stored_pos.delete();
			slots_used = 0;
			elem_count = '0;
		end
		r = '0;
		r.cur = elem_count[9:0];
		comp = longint'(target) - longint'(key);
		if (comp >= -64'sd2147483648 && comp <= 64'sd2147483647 &&
				stored_pos.exists(int'(comp))) begin
			r.found   = 1'b1;
			r.earlier = 10'(stored_pos[int'(comp)]);
		end
		if (stored_pos.exists(key)) begin
			stored_pos[key] = 32'(r.cur);
		end else if (slots_used < psh_pkg::TableEntries) begin
			stored_pos[key] = 32'(r.cur);
			slots_used++;
		end else begin
			r.full = 1'b1;
		end
		elem_count = elem_count + 11'd1;
	endtask

	task automatic send_element(input logic [31:0] raw, input bit first, input bit gaps,
			input bit typed = 1'b0, input pair_result_t typed_res = '0);
		pair_result_t r;
		if (gaps) begin
			while ($urandom_range(99) < 29)
				@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = raw;
		s_tuser  = first;
		do
			@(posedge clk);
		while (!s_tready);
		lookup_and_store(raw, first, r);
		expected_pairs.insert(expected_pairs.size(), typed ? typed_res : r);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		wait (expected_pairs.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_target(input logic [31:0] t);
		drain();
		cfg_we    = 1'b1;
		cfg_wdata = t;
		@(negedge clk);
		cfg_we = 1'b0;
		target = t;
	endtask

	// arrays drawn from a small pool so that pairs come up often
	task automatic random_arrays(input int count, input bit gaps);
		logic [31:0] pool[16];
		logic [31:0] v;
		int          len;
		int          sent;
		sent = 0;
		while (sent < count) begin
			foreach (pool[i])
				pool[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40) - 20;
			len = $urandom_range(20, 1);
			for (int k = 0; k < len && sent < count; k++) begin
				case ($urandom_range(3))
					0: v = $urandom;
					1: v = target - pool[$urandom_range(15)];
					default: v = pool[$urandom_range(15)];
				endcase
				send_element(v, k == 0 && $urandom_range(9) != 0, gaps);
				sent++;
			end
		end
	endtask

	// receiver
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				hold_off--;
			end else begin
				m_tready = steady_flow || ($urandom_range(99) >= 29);
			end
		end
	end

	always @(posedge clk) begin
		pair_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[21:0];
			if (expected_pairs.size() == 0) begin
				$display("unexpected result item %h", m_tdata);
				errors++;
			end else begin
				want = expected_pairs.pop_front();
				if (got.found !== want.found)
					report_mismatch("pair_found", got.found, want.found);
				if (got.earlier !== want.earlier)
					report_mismatch("earlier_index", got.earlier, want.earlier);
				if (got.cur !== want.cur)
					report_mismatch("current_index", got.cur, want.cur);
				if (got.full !== want.full)
					report_mismatch("table_full", got.full, want.full);
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		element_row_t rows[$];
		logic [31:0]  targets[5];
		rows = '{
			'{32'd5,        1'b0, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b0}},
			'{-32'sd5,      1'b0, 1'b1, '{1'b0, 10'd1, 10'd0, 1'b1}},
			'{32'd0,        1'b0, 1'b1, '{1'b0, 10'd2, 10'd0, 1'b0}},
			'{32'd0,        1'b0, 1'b1, '{1'b0, 10'd3, 10'd2, 1'b1}},
			'{32'h8000_0000, 1'b0, 1'b1, '{1'b0, 10'd4, 10'd0, 1'b0}},
			'{32'h7fff_ffff, 1'b0, 1'b1, '{1'b0, 10'd5, 10'd0, 1'b0}},
			'{32'h8000_0001, 1'b0, 1'b1, '{1'b0, 10'd6, 10'd5, 1'b1}},
			'{32'd5,        1'b0, 1'b1, '{1'b0, 10'd7, 10'd1, 1'b1}},
			'{-32'sd5,      1'b0, 1'b1, '{1'b0, 10'd8, 10'd7, 1'b1}},
			'{32'd1,        1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b0}},
			'{-32'sd1,      1'b0, 1'b1, '{1'b0, 10'd1, 10'd0, 1'b1}},
			'{32'hffff_ffff, 1'b0, 1'b0, '0},
			'{32'h8000_0000, 1'b1, 1'b0, '0},
			'{32'h7fff_ffff, 1'b0, 1'b0, '0},
			'{32'h8000_0000, 1'b0, 1'b0, '0},
			'{32'h7fff_ffff, 1'b0, 1'b0, '0},
			'{32'h5555_aaaa, 1'b0, 1'b0, '0},
			'{32'haaaa_5555, 1'b0, 1'b0, '0}
		};
		targets = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, $urandom, 32'd0};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < rows.size(); i++) begin
			if (i == 11)
				write_target(32'hffff_ffff);
			send_element(rows[i].value, rows[i].first, 1'b1, rows[i].typed, rows[i].res);
		end

		// hold the receiver off while items keep coming, so the input stalls
		drain();
		hold_off = 300;
		for (int i = 0; i < 20; i++)
			send_element($urandom_range(7), i == 0, 1'b0);

		foreach (targets[t]) begin
			write_target(targets[t]);
			steady_flow = (t == 2);
			random_arrays(90, !steady_flow);
		end
		steady_flow = 1'b0;

		// one short array of distinct odd values, then lookups against it
		write_target(32'd0);
		for (int i = 0; i < 20; i++)
			send_element(32'(2 * i + 1), i == 0, 1'b0);
		send_element(32'd1, 1'b0, 1'b1);
		send_element(-32'sd1, 1'b0, 1'b1);
		send_element(32'd3, 1'b0, 1'b1);

		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
